FILE: src/rpf_pkg.sv
// Package with shared constants, types and register codes of the resonance peak finder.
package rpf_pkg;

  // Size of the peak list and the width of its fill counter.
  localparam int unsigned MAX_PEAKS = 30;
  localparam int unsigned COUNT_W   = $clog2(MAX_PEAKS + 1);

  // Field widths.
  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned SPREAD_W = 19;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_MERGE_DISTANCE = 2'd0;
  localparam logic [1:0] REG_NOISE_CUTOFF   = 2'd1;
  localparam logic [1:0] REG_IGNORE_NOISE   = 2'd2;

  // Register reset values.
  localparam logic [FREQ_W-1:0] MERGE_DISTANCE_RST = 20'd160;
  localparam logic [FREQ_W-1:0] NOISE_CUTOFF_RST   = 20'd640;

  // What a reported peak did to the list.
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_MERGE  = 2'd1,
    ACT_DROP   = 2'd2
  } action_t;

  // Configuration as seen by the detector.
  typedef struct packed {
    logic [FREQ_W-1:0] merge_distance;
    logic [FREQ_W-1:0] noise_cutoff;
    logic              ignore_noise;
  } cfg_t;

endpackage

FILE: src/rpf_if.sv
// Handshake interfaces for the sample request and the peak request channels.
interface rpf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [rpf_pkg::FREQ_W-1:0]    sample_freq;
  logic [rpf_pkg::MAG_W-1:0]     sample_mag;
  logic                          first_sample;

  modport source (output valid, output sample_freq, output sample_mag,
                  output first_sample, input ready);
  modport sink (input valid, input sample_freq, input sample_mag,
                input first_sample, output ready);
endinterface

interface rpf_peak_if;
  logic                          valid;
  logic                          ready;
  rpf_pkg::action_t              peak_action;
  logic [rpf_pkg::INDEX_W-1:0]   peak_index;
  logic [rpf_pkg::FREQ_W-1:0]    peak_freq;
  logic [rpf_pkg::MAG_W-1:0]     peak_mag;
  logic [rpf_pkg::SPREAD_W-1:0]  peak_spread;

  modport source (output valid, output peak_action, output peak_index,
                  output peak_freq, output peak_mag, output peak_spread, input ready);
  modport sink (input valid, input peak_action, input peak_index,
                input peak_freq, input peak_mag, input peak_spread, output ready);
endinterface

FILE: src/rpf_cfg_regs.sv
// APB-style configuration registers of the resonance peak finder.
module rpf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpf_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpf_pkg::DATA_W-1:0]  pwdata,
  output logic [rpf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rpf_pkg::cfg_t               cfg
);

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.merge_distance <= rpf_pkg::MERGE_DISTANCE_RST;
      cfg.noise_cutoff   <= rpf_pkg::NOISE_CUTOFF_RST;
      cfg.ignore_noise   <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        rpf_pkg::REG_MERGE_DISTANCE: cfg.merge_distance <= pwdata[rpf_pkg::FREQ_W-1:0];
        rpf_pkg::REG_NOISE_CUTOFF:   cfg.noise_cutoff   <= pwdata[rpf_pkg::FREQ_W-1:0];
        rpf_pkg::REG_IGNORE_NOISE:   cfg.ignore_noise   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (reg_sel)
      rpf_pkg::REG_MERGE_DISTANCE:
        prdata = rpf_pkg::DATA_W'(cfg.merge_distance);
      rpf_pkg::REG_NOISE_CUTOFF:
        prdata = rpf_pkg::DATA_W'(cfg.noise_cutoff);
      rpf_pkg::REG_IGNORE_NOISE:
        prdata = rpf_pkg::DATA_W'(cfg.ignore_noise);
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: src/rpf_core.sv
// Peak detector: input register, curve state, peak decision and result register.
module rpf_core (
  input  logic                 clk,
  input  logic                 rst,
  input  rpf_pkg::cfg_t        cfg,
  rpf_sample_if.sink           sample,
  rpf_peak_if.source           peak
);

  // Input register.
  logic                          in_valid;
  logic [rpf_pkg::FREQ_W-1:0]    in_freq;
  logic [rpf_pkg::MAG_W-1:0]     in_mag;
  logic                          in_first;

  // Curve state.
  logic [rpf_pkg::FREQ_W-1:0]    prev_freq;
  logic [rpf_pkg::MAG_W-1:0]     prev_mag;
  logic [1:0]                    rise_history;
  logic [1:0]                    samples_seen;
  logic [rpf_pkg::FREQ_W-1:0]    ref_peak_freq;
  logic [rpf_pkg::MAG_W-1:0]     ref_peak_mag;
  logic [rpf_pkg::COUNT_W-1:0]   peak_count;

  // Decision logic.
  logic                          restart;
  logic                          rise_now;
  logic                          noise_skip;
  logic                          is_peak;
  logic                          is_append;
  logic                          list_full;
  logic [rpf_pkg::FREQ_W:0]      freq_gap;
  logic [rpf_pkg::FREQ_W:0]      freq_sum;
  logic [rpf_pkg::FREQ_W-1:0]    freq_span;
  logic [rpf_pkg::MAG_W-1:0]     mag_max;
  logic                          advance;

  assign restart    = in_first || (samples_seen == 2'd0);
  assign rise_now   = prev_mag < in_mag;
  assign noise_skip = cfg.ignore_noise && (prev_freq < cfg.noise_cutoff);
  assign is_peak    = !restart && rise_history[1] && rise_history[0] && !rise_now
                      && !noise_skip;

  // Distance of the candidate from the reference peak; bit 20 set means below it.
  assign freq_gap  = {1'b0, prev_freq} - {1'b0, ref_peak_freq};
  assign freq_sum  = {1'b0, prev_freq} + {1'b0, ref_peak_freq};
  assign freq_span = freq_gap[rpf_pkg::FREQ_W] ? (ref_peak_freq - prev_freq)
                                               : freq_gap[rpf_pkg::FREQ_W-1:0];
  assign mag_max   = (prev_mag > ref_peak_mag) ? prev_mag : ref_peak_mag;

  // A merge into an empty list is taken as an append.
  assign is_append = (!freq_gap[rpf_pkg::FREQ_W]
                      && (freq_gap[rpf_pkg::FREQ_W-1:0] > cfg.merge_distance))
                     || (peak_count == '0);
  assign list_full = peak_count == rpf_pkg::COUNT_W'(rpf_pkg::MAX_PEAKS);

  // The held request moves on unless it has a result and the result slot is blocked.
  assign advance      = in_valid && (!is_peak || !peak.valid || peak.ready);
  assign sample.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
    if (sample.valid && sample.ready) begin
      in_freq  <= sample.sample_freq;
      in_mag   <= sample.sample_mag;
      in_first <= sample.first_sample;
    end
  end

  // Curve state update for each request that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_freq     <= '0;
      prev_mag      <= '0;
      rise_history  <= '0;
      samples_seen  <= '0;
      ref_peak_freq <= '0;
      ref_peak_mag  <= '0;
      peak_count    <= '0;
    end else if (advance) begin
      prev_freq <= in_freq;
      prev_mag  <= in_mag;
      if (restart) begin
        rise_history  <= '0;
        samples_seen  <= 2'd1;
        ref_peak_freq <= '0;
        ref_peak_mag  <= '0;
        if (in_first) begin
          peak_count <= '0;
        end
      end else begin
        rise_history <= {rise_history[0], rise_now};
        if (samples_seen != 2'd2) begin
          samples_seen <= samples_seen + 2'd1;
        end
        if (is_peak && is_append) begin
          ref_peak_freq <= prev_freq;
          ref_peak_mag  <= prev_mag;
          if (!list_full) begin
            peak_count <= peak_count + rpf_pkg::COUNT_W'(1);
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak.valid <= 1'b0;
    end else if (advance && is_peak) begin
      peak.valid <= 1'b1;
    end else if (peak.ready) begin
      peak.valid <= 1'b0;
    end
    if (advance && is_peak) begin
      if (is_append) begin
        peak.peak_action <= list_full ? rpf_pkg::ACT_DROP : rpf_pkg::ACT_APPEND;
        peak.peak_index  <= list_full ? '0 : rpf_pkg::INDEX_W'(peak_count);
        peak.peak_freq   <= prev_freq;
        peak.peak_mag    <= prev_mag;
        peak.peak_spread <= '0;
      end else begin
        peak.peak_action <= rpf_pkg::ACT_MERGE;
        peak.peak_index  <= rpf_pkg::INDEX_W'(peak_count - rpf_pkg::COUNT_W'(1));
        peak.peak_freq   <= freq_sum[rpf_pkg::FREQ_W:1];
        peak.peak_mag    <= mag_max;
        peak.peak_spread <= freq_span[rpf_pkg::FREQ_W-1:1];
      end
    end
  end

`ifndef SYNTH
  // The list never holds more than its limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    peak_count <= rpf_pkg::COUNT_W'(rpf_pkg::MAX_PEAKS))
    else $error("peak count above list limit");

  // A marked first sample empties the list.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && in_first) |=> (peak_count == '0))
    else $error("restart did not clear the peak count");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (peak.valid && !peak.ready) |-> !(advance && is_peak))
    else $error("result register overwritten while stalled");

  // A merge always has a list entry to merge into.
  a_merge_nonempty: assert property (@(posedge clk) disable iff (rst)
    (advance && is_peak && !is_append) |-> (peak_count != '0))
    else $error("merge into an empty list");
`endif

endmodule

FILE: src/resonance_peak_finder.sv
// Top level of the resonance peak finder: configuration registers and detector core.
// The block takes one sample request per clock cycle and keeps that rate under any
// stall pattern that leaves the result slot free. A sample is held in the input
// register, where compare, add and shift logic decides on the previous sample and
// updates the curve state; a peak request is registered as its confirming sample
// leaves that register. Samples that give no peak never wait on the output side;
// a sample that gives a peak waits only while an earlier peak is still not taken.
// Write the configuration registers only while no sample is in flight.
module resonance_peak_finder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpf_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpf_pkg::DATA_W-1:0]  pwdata,
  output logic [rpf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  rpf_sample_if.sink                  sample_in,
  rpf_peak_if.source                  peak_out
);

  rpf_pkg::cfg_t cfg;

  // Configuration registers.
  rpf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Detector.
  rpf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample_in),
    .peak   (peak_out)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the resonance peak finder: directed curves, then random ones.
module testbench;

  // One sample request and one expected or observed peak request.
  typedef struct packed {
    logic [rpf_pkg::FREQ_W-1:0] freq;
    logic [rpf_pkg::MAG_W-1:0]  mag;
    logic                       first;
  } sample_t;

  typedef struct packed {
    rpf_pkg::action_t             action;
    logic [rpf_pkg::INDEX_W-1:0]  index;
    logic [rpf_pkg::FREQ_W-1:0]   freq;
    logic [rpf_pkg::MAG_W-1:0]    mag;
    logic [rpf_pkg::SPREAD_W-1:0] spread;
  } peak_t;

  // A row of the directed table; has_peak marks a peak typed in by hand.
  typedef struct packed {
    sample_t req;
    logic    has_peak;
    peak_t   peak;
  } stim_row_t;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned NUM_PHASES     = 5;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rpf_pkg::ADDR_W-1:0] paddr;
  logic [rpf_pkg::DATA_W-1:0] pwdata;
  logic [rpf_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  rpf_sample_if sample_if ();
  rpf_peak_if   peak_if ();

  resonance_peak_finder DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sample_in (sample_if),
    .peak_out  (peak_if)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Own copy of the detector configuration and curve state.
  rpf_pkg::cfg_t               cfg;
  logic [rpf_pkg::FREQ_W-1:0]  det_prev_freq;
  logic [rpf_pkg::MAG_W-1:0]   det_prev_mag;
  logic [1:0]                  det_rise;
  logic [1:0]                  det_seen;
  logic [rpf_pkg::FREQ_W-1:0]  det_ref_freq;
  logic [rpf_pkg::MAG_W-1:0]   det_ref_mag;
  logic [rpf_pkg::COUNT_W-1:0] det_count;

  peak_t       pending_peaks[$];
  int unsigned error_count    = 0;
  int unsigned stalled_cycles = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // Random curve generator state.
  int unsigned                curve_left = 0;
  int unsigned                run_left   = 0;
  bit                         rising     = 1'b1;
  logic [rpf_pkg::FREQ_W-1:0] curve_freq;
  logic [rpf_pkg::MAG_W-1:0]  curve_mag;

  // Settings of the random phases: register values and idling rates.
  logic [rpf_pkg::FREQ_W-1:0] phase_merge [NUM_PHASES] =
    '{20'd0, 20'hFFFFF, 20'd160, 20'd40, 20'd0};
  logic [rpf_pkg::FREQ_W-1:0] phase_cutoff[NUM_PHASES] =
    '{20'd0, 20'hFFFFF, 20'd2000, 20'd1000, 20'd640};
  logic              phase_ignore[NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  int unsigned       phase_items [NUM_PHASES] = '{100, 100, 100, 100, 200};
  int unsigned       phase_gap   [NUM_PHASES] = '{0, 70, 0, 12, 0};
  int unsigned       phase_stall [NUM_PHASES] = '{0, 0, 70, 12, 0};

  // Directed curves under the reset configuration. Peaks typed in are the plain appends.
  stim_row_t directed_rows[24] = '{
    // No curve started: the first sample after reset lacks the first mark.
    '{'{20'd1000, 32'd5, 1'b0}, 1'b0, '0},
    '{'{20'd1100, 32'd10, 1'b0}, 1'b0, '0},
    '{'{20'd1200, 32'd20, 1'b0}, 1'b0, '0},
    '{'{20'd1300, 32'd15, 1'b0}, 1'b1,
      '{rpf_pkg::ACT_APPEND, 5'd0, 20'd1200, 32'd20, 19'd0}},
    // A flat step ends the rise; the gap is wide enough to append.
    '{'{20'd1400, 32'd30, 1'b0}, 1'b0, '0},
    '{'{20'd1450, 32'd40, 1'b0}, 1'b0, '0},
    '{'{20'd1500, 32'd40, 1'b0}, 1'b1,
      '{rpf_pkg::ACT_APPEND, 5'd1, 20'd1450, 32'd40, 19'd0}},
    // Close peak merges at the midpoint of the two frequencies.
    '{'{20'd1510, 32'd50, 1'b0}, 1'b0, '0},
    '{'{20'd1520, 32'd60, 1'b0}, 1'b0, '0},
    '{'{20'd1530, 32'd0, 1'b0}, 1'b0, '0},
    // Gap of exactly the merge distance still merges.
    '{'{20'd1600, 32'd1, 1'b0}, 1'b0, '0},
    '{'{20'd1610, 32'd100, 1'b0}, 1'b0, '0},
    '{'{20'd1620, 32'd100, 1'b0}, 1'b0, '0},
    // Peak below the reference frequency merges, at the largest magnitude.
    '{'{20'd100, 32'd200, 1'b0}, 1'b0, '0},
    '{'{20'd110, 32'hFFFFFFFF, 1'b0}, 1'b0, '0},
    '{'{20'd0, 32'hFFFFFFFF, 1'b0}, 1'b0, '0},
    // Restart, then a peak at the top frequency.
    '{'{20'd0, 32'd0, 1'b1}, 1'b0, '0},
    '{'{20'hFFFFF, 32'd1, 1'b0}, 1'b0, '0},
    '{'{20'hFFFFF, 32'd2, 1'b0}, 1'b0, '0},
    '{'{20'd0, 32'd1, 1'b0}, 1'b1,
      '{rpf_pkg::ACT_APPEND, 5'd0, 20'hFFFFF, 32'd2, 19'd0}},
    // Restart, then a merge into the empty list, which appends.
    '{'{20'd5, 32'd7, 1'b1}, 1'b0, '0},
    '{'{20'd10, 32'd8, 1'b0}, 1'b0, '0},
    '{'{20'd20, 32'd9, 1'b0}, 1'b0, '0},
    '{'{20'd30, 32'd9, 1'b0}, 1'b1,
      '{rpf_pkg::ACT_APPEND, 5'd0, 20'd20, 32'd9, 19'd0}}
  };

  // Counts a failure; only the first few are described.
  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Advances the curve state by one sample and returns whether a peak is reported.
  function automatic bit detect_peak(input sample_t s, output peak_t p);
    logic                       rise_old;
    logic                       rise_new;
    logic                       rise_now;
    logic [rpf_pkg::FREQ_W:0]   freq_sum;
    logic [rpf_pkg::FREQ_W-1:0] gap;
    bit                         found;
    found = 1'b0;
    p = '0;
    // A first mark, or no sample since reset, restarts the curve.
    if (s.first || det_seen == 2'd0) begin
      det_prev_freq = s.freq;
      det_prev_mag  = s.mag;
      det_rise      = 2'b00;
      det_seen      = 2'd1;
      det_ref_freq  = '0;
      det_ref_mag   = '0;
      if (s.first) begin
        det_count = '0;
      end
      return 1'b0;
    end
    rise_old = det_rise[1];
    rise_new = det_rise[0];
    rise_now = det_prev_mag < s.mag;
    // Two rises then no rise: the previous sample is a candidate.
    if (rise_old && rise_new && !rise_now &&
        !(cfg.ignore_noise && det_prev_freq < cfg.noise_cutoff)) begin
      found = 1'b1;
      if ((det_prev_freq > det_ref_freq &&
           (det_prev_freq - det_ref_freq) > cfg.merge_distance) || det_count == '0) begin
        if (det_count < rpf_pkg::MAX_PEAKS) begin
          p.action  = rpf_pkg::ACT_APPEND;
          p.index   = rpf_pkg::INDEX_W'(det_count);
          det_count = det_count + 1'b1;
        end else begin
          p.action = rpf_pkg::ACT_DROP;
        end
        p.freq       = det_prev_freq;
        p.mag        = det_prev_mag;
        det_ref_freq = det_prev_freq;
        det_ref_mag  = det_prev_mag;
      end else begin
        gap = (det_prev_freq >= det_ref_freq) ? det_prev_freq - det_ref_freq
                                              : det_ref_freq - det_prev_freq;
        freq_sum = det_prev_freq + det_ref_freq;
        p.action = rpf_pkg::ACT_MERGE;
        p.index  = rpf_pkg::INDEX_W'(det_count - 1'b1);
        p.freq   = freq_sum[rpf_pkg::FREQ_W:1];
        p.mag    = (det_prev_mag > det_ref_mag) ? det_prev_mag : det_ref_mag;
        p.spread = gap[rpf_pkg::FREQ_W-1:1];
      end
    end
    det_rise      = {rise_new, rise_now};
    det_prev_freq = s.freq;
    det_prev_mag  = s.mag;
    if (det_seen < 2'd2) begin
      det_seen = det_seen + 1'b1;
    end
    return found;
  endfunction

  // Presents one sample request and records the peak it should cause.
  task automatic send_sample(input sample_t s, input bit has_peak, input peak_t typed_peak);
    peak_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid        <= 1'b1;
    sample_if.sample_freq  <= s.freq;
    sample_if.sample_mag   <= s.mag;
    sample_if.first_sample <= s.first;
    // Ready is stable in the second half of the cycle; it tells whether the next edge accepts.
    @(negedge clk);
    while (!sample_if.ready) begin
      @(negedge clk);
    end
    @(posedge clk);
    if (detect_peak(s, predicted) || has_peak) begin
      pending_peaks.push_back(has_peak ? typed_peak : predicted);
    end
  endtask

  // Writes a register, reads it back and mirrors it in the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [rpf_pkg::FREQ_W-1:0] value);
    logic [rpf_pkg::DATA_W-1:0] stored;
    stored = (idx == rpf_pkg::REG_IGNORE_NOISE) ? rpf_pkg::DATA_W'(value[0])
                                                : rpf_pkg::DATA_W'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rpf_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= stored;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      rpf_pkg::REG_MERGE_DISTANCE: cfg.merge_distance = value;
      rpf_pkg::REG_NOISE_CUTOFF:   cfg.noise_cutoff   = value;
      rpf_pkg::REG_IGNORE_NOISE:   cfg.ignore_noise   = value[0];
      default: ;
    endcase
    // Read back from the same address.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) begin
      note_error($sformatf("register %0d reads %h, expected %h", idx, prdata, stored));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending and waits until every expected peak has come and the pipeline is empty.
  task automatic settle();
    sample_if.valid <= 1'b0;
    while (pending_peaks.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Produces curves that rise and fall in runs, with some noise and broken sequences.
  task automatic next_random_sample(output sample_t s);
    logic [rpf_pkg::MAG_W-1:0] delta;
    // Noise: any value, sometimes with a restart.
    if ($urandom_range(0, 99) < 6) begin
      s.freq  = rpf_pkg::FREQ_W'($urandom);
      s.mag   = $urandom;
      s.first = ($urandom_range(0, 3) == 0);
      return;
    end
    if (curve_left == 0) begin
      curve_left = $urandom_range(8, 250);
      curve_freq = ($urandom_range(0, 3) == 0) ? rpf_pkg::FREQ_W'($urandom)
                                               : rpf_pkg::FREQ_W'($urandom_range(0, 3000));
      curve_mag  = $urandom;
      rising     = 1'b1;
      run_left   = $urandom_range(2, 4);
      s.first    = 1'b1;
    end else begin
      curve_freq = curve_freq +
                   (($urandom_range(0, 7) == 0) ? rpf_pkg::FREQ_W'($urandom_range(0, 400))
                                                : rpf_pkg::FREQ_W'($urandom_range(0, 60)));
      if (run_left == 0) begin
        rising   = !rising;
        run_left = rising ? $urandom_range(2, 4) : $urandom_range(1, 2);
      end
      run_left--;
      delta     = $urandom_range(0, 65536);
      curve_mag = rising ? curve_mag + delta : curve_mag - delta;
      s.first   = 1'b0;
    end
    curve_left--;
    s.freq = curve_freq;
    s.mag  = curve_mag;
  endtask

  // Result side: ready with random stalls, and the check of every accepted peak.
  always @(posedge clk) begin
    if (rst) begin
      peak_if.ready <= 1'b0;
    end else begin
      peak_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    peak_t got;
    peak_t want;
    if (!rst && peak_if.valid && peak_if.ready) begin
      got = '{peak_if.peak_action, peak_if.peak_index, peak_if.peak_freq,
              peak_if.peak_mag, peak_if.peak_spread};
      if (pending_peaks.size() == 0) begin
        note_error($sformatf("unexpected peak: act=%0d idx=%0d freq=%h mag=%h spread=%h",
                             got.action, got.index, got.freq, got.mag, got.spread));
      end else begin
        want = pending_peaks.pop_front();
        if (got.action !== want.action || got.index !== want.index ||
            got.freq !== want.freq || got.mag !== want.mag || got.spread !== want.spread) begin
          note_error($sformatf({"peak mismatch: expected act=%0d idx=%0d freq=%h mag=%h ",
                                "spread=%h, got act=%0d idx=%0d freq=%h mag=%h spread=%h"},
                               want.action, want.index, want.freq, want.mag, want.spread,
                               got.action, got.index, got.freq, got.mag, got.spread));
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk) begin
    if ((sample_if.valid && sample_if.ready) || (peak_if.valid && peak_if.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin
    int unsigned phase;
    int unsigned n;
    sample_t     s;
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sample_if.valid        = 1'b0;
    sample_if.sample_freq  = '0;
    sample_if.sample_mag   = '0;
    sample_if.first_sample = 1'b0;
    peak_if.ready          = 1'b0;
    cfg.merge_distance     = rpf_pkg::MERGE_DISTANCE_RST;
    cfg.noise_cutoff       = rpf_pkg::NOISE_CUTOFF_RST;
    cfg.ignore_noise       = 1'b0;
    det_prev_freq          = '0;
    det_prev_mag           = '0;
    det_rise               = '0;
    det_seen               = '0;
    det_ref_freq           = '0;
    det_ref_mag            = '0;
    det_count              = '0;
    curve_freq             = '0;
    curve_mag              = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].req, directed_rows[i].has_peak, directed_rows[i].peak);
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_reg(rpf_pkg::REG_MERGE_DISTANCE, phase_merge[phase]);
      write_reg(rpf_pkg::REG_NOISE_CUTOFF, phase_cutoff[phase]);
      write_reg(rpf_pkg::REG_IGNORE_NOISE, rpf_pkg::FREQ_W'(phase_ignore[phase]));
      send_gap_pct   = phase_gap[phase];
      recv_stall_pct = phase_stall[phase];
      for (n = 0; n < phase_items[phase]; n++) begin
        next_random_sample(s);
        send_sample(s, 1'b0, '0);
      end
    end
    settle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: resonance_peak_finder.f
src/rpf_pkg.sv
src/rpf_if.sv
src/rpf_cfg_regs.sv
src/rpf_core.sv
src/resonance_peak_finder.sv
test/testbench.sv
